[src/fmcm_pkg.sv]
// Shared constants and types of the fill mode coordinate mapper.
`default_nettype none
package fmcm_pkg;
	localparam int DEF_MAX_DIM_BITS = 12;
	localparam int DEF_FRAC_BITS = 4;
	localparam int DIV_STEPS = 4;
	localparam int IDX_W = 3;
	localparam int OUT_XY_W = 16;
	localparam int OUT_WH_W = 15;
	localparam int OUT_S_MAX = 32767;
	localparam int OUT_S_MIN = -32768;
	localparam int OUT_U_MAX = 32767;

	localparam int RST_SCREEN_W = 1404;
	localparam int RST_SCREEN_H = 1872;
	localparam int RST_FB_W = 1404;
	localparam int RST_FB_H = 1872;

	typedef enum logic [IDX_W-1:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_FB_W = 3'd2,
		REG_FB_H = 3'd3,
		REG_FILL_MODE = 3'd4,
		REG_ALLOW_SCALING = 3'd5,
		REG_IMAGE_PRESENT = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		FILL_STRETCH = 2'd0,
		FILL_FIT = 2'd1,
		FILL_CROP = 2'd2,
		FILL_PAD = 2'd3
	} fill_mode_t;
endpackage
`default_nettype wire

[src/fmcm_if.sv]
// Request and response channel interfaces of the mapper.
`default_nettype none
interface fmcm_req_if
	import fmcm_pkg::*;
#(
	parameter int MAX_DIM_BITS = DEF_MAX_DIM_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
);
	logic valid;
	logic ready;
	logic kind;
	logic signed [MAX_DIM_BITS+FRAC_BITS:0] point_x;
	logic signed [MAX_DIM_BITS+FRAC_BITS:0] point_y;
	logic [MAX_DIM_BITS-1:0] rect_left;
	logic [MAX_DIM_BITS-1:0] rect_top;
	logic [MAX_DIM_BITS:0] rect_width;
	logic [MAX_DIM_BITS:0] rect_height;

	modport source(output valid, kind, point_x, point_y, rect_left, rect_top, rect_width,
		rect_height, input ready);
	modport sink(input valid, kind, point_x, point_y, rect_left, rect_top, rect_width,
		rect_height, output ready);
endinterface

interface fmcm_rsp_if
	import fmcm_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [OUT_XY_W-1:0] out_x;
	logic signed [OUT_XY_W-1:0] out_y;
	logic [OUT_WH_W-1:0] out_width;
	logic [OUT_WH_W-1:0] out_height;
	logic inside_fb;

	modport source(output valid, out_x, out_y, out_width, out_height, inside_fb, input ready);
	modport sink(input valid, out_x, out_y, out_width, out_height, inside_fb, output ready);
endinterface
`default_nettype wire

[src/fmcm_div_pipe.sv]
// Multi-lane pipelined restoring divider with sign fix-up and sideband.
`default_nettype none
module fmcm_div_pipe
	import fmcm_pkg::*;
#(
	parameter int LANES = 5,
	parameter int NW = 33,
	parameter int DW = 18,
	parameter int SBW = 1,
	parameter int SPS = DIV_STEPS
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vld_in,
	input logic [LANES-1:0][NW-1:0] num,
	input logic [LANES-1:0] neg,
	input logic [LANES-1:0][DW-1:0] dsr,
	input logic [SBW-1:0] sb_in,
	output logic vld_out,
	output logic [LANES-1:0][NW:0] quo,
	output logic [SBW-1:0] sb_out
);
	localparam int NST = (NW + SPS - 1) / SPS;
	localparam int NWP = NST * SPS;

	logic vld_s [NST];
	logic [LANES-1:0][NWP-1:0] nq_s [NST];
	logic [LANES-1:0][DW-1:0] rem_s [NST];
	logic [LANES-1:0][DW-1:0] dsr_s [NST];
	logic [LANES-1:0] neg_s [NST];
	logic [SBW-1:0] sb_s [NST];

	for (genvar g = 0; g < NST; g++) begin : g_st
		logic [LANES-1:0][NWP-1:0] nq_i, nq_o;
		logic [LANES-1:0][DW-1:0] rem_i, rem_o, d_i;
		logic [LANES-1:0] neg_i;
		logic [SBW-1:0] sb_i;
		logic v_i;

		if (g == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					nq_i[l] = NWP'(num[l]);
					rem_i[l] = '0;
				end
			end
			assign d_i = dsr;
			assign neg_i = neg;
			assign sb_i = sb_in;
			assign v_i = vld_in;
		end else begin : g_next
			assign nq_i = nq_s[g-1];
			assign rem_i = rem_s[g-1];
			assign d_i = dsr_s[g-1];
			assign neg_i = neg_s[g-1];
			assign sb_i = sb_s[g-1];
			assign v_i = vld_s[g-1];
		end

		always_comb begin
			logic [DW:0] r;
			nq_o = nq_i;
			rem_o = rem_i;
			r = '0;
			for (int l = 0; l < LANES; l++) begin
				for (int s = 0; s < SPS; s++) begin
					r = {rem_o[l], nq_o[l][NWP-1]};
					nq_o[l] = {nq_o[l][NWP-2:0], 1'b0};
					if (r >= {1'b0, d_i[l]}) begin
						r = r - {1'b0, d_i[l]};
						nq_o[l][0] = 1'b1;
					end
					rem_o[l] = r[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[g] <= nq_o;
				rem_s[g] <= rem_o;
				dsr_s[g] <= d_i;
				neg_s[g] <= neg_i;
				sb_s[g] <= sb_i;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			quo[l] = neg_s[NST-1][l] ? -{1'b0, nq_s[NST-1][l][NW-1:0]}
				: {1'b0, nq_s[NST-1][l][NW-1:0]};
		end
	end

	assign vld_out = vld_s[NST-1];
	assign sb_out = sb_s[NST-1];
endmodule
`default_nettype wire

[src/fill_mode_coordinate_mapper.sv]
// Top level of the fill mode coordinate mapper.
// Maps screen points to framebuffer pixels and framebuffer rects to screen rects under
// stretch, aspect fit, aspect crop and centered pad modes. Fully pipelined: one beat per
// cycle in and out unless a response waits unaccepted, which stalls every stage. The
// pipelined restoring dividers retire four quotient bits per stage. Results are exact
// integer math: truncation toward zero, rect sizes rounded up in fit and crop, all outputs
// saturated. Write registers only while no beat is in flight.
`default_nettype none
module fill_mode_coordinate_mapper
	import fmcm_pkg::*;
#(
	parameter int MAX_DIM_BITS = DEF_MAX_DIM_BITS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_idx,
	input logic [MAX_DIM_BITS:0] wr_data,
	fmcm_req_if.sink req,
	fmcm_rsp_if.source rsp
);
	localparam int SZW = MAX_DIM_BITS + 1;
	localparam int PTW = MAX_DIM_BITS + FRAC_BITS + 1;
	localparam int AW = PTW + 1;
	localparam int PW = AW + SZW + 1;
	localparam int NSW = PW + 2;
	localparam int NMW = NSW - 1;
	localparam int DW = SZW + FRAC_BITS + 1;
	localparam int DFW = 2 * SZW + 1;
	localparam int CW = SZW + 1;
	localparam int QW = NMW + 1;
	localparam int FW = QW + 2;
	localparam int LN = 5;
	localparam int SBW = 3 + 2 * CW;
	localparam logic signed [FW-1:0] X_MAX = FW'(OUT_S_MAX);
	localparam logic signed [FW-1:0] X_MIN = FW'(OUT_S_MIN);
	localparam logic signed [FW-1:0] W_MAX = FW'(OUT_U_MAX);

	// configuration
	logic [SZW-1:0] sw_q, sh_q, fw_q, fh_q;
	fill_mode_t mode_q;
	logic scale_q, img_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= SZW'(RST_SCREEN_W);
			sh_q <= SZW'(RST_SCREEN_H);
			fw_q <= SZW'(RST_FB_W);
			fh_q <= SZW'(RST_FB_H);
			mode_q <= FILL_STRETCH;
			scale_q <= 1'b1;
			img_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_idx))
				REG_SCREEN_W: sw_q <= wr_data;
				REG_SCREEN_H: sh_q <= wr_data;
				REG_FB_W: fw_q <= wr_data;
				REG_FB_H: fh_q <= wr_data;
				REG_FILL_MODE: mode_q <= fill_mode_t'(wr_data[1:0]);
				REG_ALLOW_SCALING: scale_q <= wr_data[0];
				REG_IMAGE_PRESENT: img_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	logic [SZW-1:0] sw, sh, fw, fh;
	assign sw = (sw_q == '0) ? SZW'(1) : sw_q;
	assign sh = (sh_q == '0) ? SZW'(1) : sh_q;
	assign fw = (fw_q == '0) ? SZW'(1) : fw_q;
	assign fh = (fh_q == '0) ? SZW'(1) : fh_q;

	logic adv;
	assign adv = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	// stage 1: capture beat, aspect cross products
	logic v_s1, kind_s1;
	logic signed [PTW-1:0] px_s1, py_s1;
	logic [MAX_DIM_BITS-1:0] l_s1, t_s1;
	logic [SZW-1:0] rw_s1, rh_s1;
	logic [2*SZW-1:0] pa_s1, pb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= req.kind;
			px_s1 <= req.point_x;
			py_s1 <= req.point_y;
			l_s1 <= req.rect_left;
			t_s1 <= req.rect_top;
			rw_s1 <= req.rect_width;
			rh_s1 <= req.rect_height;
			pa_s1 <= fw * sh;
			pb_s1 <= sw * fh;
		end
	end

	// stage 2: mode decode, per-lane operands
	logic signed [AW-1:0] a_c [LN];
	logic [SZW-1:0] b_c [LN];
	logic signed [NSW-1:0] k_c [LN];
	logic [DW-1:0] d_c [LN];
	logic [LN-1:0] dbl_c;
	logic ox_c, oy_c;
	logic signed [CW-1:0] ax_c, ay_c;
	logic signed [DFW-1:0] diff;
	logic signed [CW-1:0] dx, dy, dxr, dyr, cx, cy;
	logic wider, fill_w;

	assign diff = $signed({1'b0, pa_s1}) - $signed({1'b0, pb_s1});
	assign wider = pa_s1 > pb_s1;
	assign fill_w = (mode_q == FILL_FIT && wider) || (mode_q == FILL_CROP && !wider);
	assign dx = $signed({1'b0, sw}) - $signed({1'b0, fw});
	assign dy = $signed({1'b0, sh}) - $signed({1'b0, fh});
	assign dxr = dx + $signed({{(CW-1){1'b0}}, dx[CW-1]});
	assign dyr = dy + $signed({{(CW-1){1'b0}}, dy[CW-1]});
	assign cx = dxr >>> 1;
	assign cy = dyr >>> 1;

	always_comb begin
		logic [DW-1:0] d32, dsw, dsh;
		d32 = DW'(2) << FRAC_BITS;
		dsw = DW'(sw) << (FRAC_BITS + 1);
		dsh = DW'(sh) << (FRAC_BITS + 1);
		for (int l = 0; l < LN; l++) begin
			a_c[l] = '0;
			b_c[l] = '0;
			k_c[l] = '0;
			d_c[l] = DW'(1);
		end
		dbl_c = '0;
		ox_c = 1'b0;
		oy_c = 1'b0;
		ax_c = '0;
		ay_c = '0;
		if (!kind_s1) begin
			dbl_c[0] = 1'b1;
			dbl_c[1] = 1'b1;
			a_c[0] = AW'(px_s1);
			a_c[1] = AW'(py_s1);
			if (!scale_q || !img_q) begin
				b_c[0] = SZW'(1);
				b_c[1] = SZW'(1);
				d_c[0] = d32;
				d_c[1] = d32;
			end else if (mode_q == FILL_STRETCH) begin
				b_c[0] = fw;
				d_c[0] = dsw;
				b_c[1] = fh;
				d_c[1] = dsh;
			end else if (mode_q == FILL_PAD) begin
				b_c[0] = SZW'(1);
				b_c[1] = SZW'(1);
				k_c[0] = -(NSW'(cx) <<< (FRAC_BITS + 1));
				k_c[1] = -(NSW'(cy) <<< (FRAC_BITS + 1));
				d_c[0] = d32;
				d_c[1] = d32;
			end else if (fill_w) begin
				b_c[0] = fw;
				d_c[0] = dsw;
				b_c[1] = fw;
				k_c[1] = -(NSW'(diff) <<< FRAC_BITS);
				d_c[1] = dsw;
			end else begin
				b_c[0] = fh;
				k_c[0] = NSW'(diff) <<< FRAC_BITS;
				d_c[0] = dsh;
				b_c[1] = fh;
				d_c[1] = dsh;
			end
		end else begin
			a_c[0] = AW'(l_s1);
			a_c[1] = AW'(t_s1);
			a_c[2] = AW'(rw_s1);
			a_c[3] = AW'(rh_s1);
			if (!img_q || !scale_q || mode_q == FILL_PAD) begin
				for (int l = 0; l < 4; l++) begin
					b_c[l] = SZW'(1);
				end
				if (img_q) begin
					ax_c = cx;
					ay_c = cy;
				end
			end else if (mode_q == FILL_STRETCH) begin
				b_c[0] = sw;
				d_c[0] = DW'(fw);
				b_c[1] = sh;
				d_c[1] = DW'(fh);
				b_c[2] = sw;
				d_c[2] = DW'(fw);
				b_c[3] = sh;
				d_c[3] = DW'(fh);
			end else if (fill_w) begin
				for (int l = 0; l < 4; l++) begin
					b_c[l] = sw;
					d_c[l] = DW'(fw);
				end
				k_c[2] = NSW'(fw) - NSW'(1);
				k_c[3] = NSW'(fw) - NSW'(1);
				k_c[4] = NSW'(diff);
				d_c[4] = DW'(fw) << 1;
				oy_c = 1'b1;
			end else begin
				for (int l = 0; l < 4; l++) begin
					b_c[l] = sh;
					d_c[l] = DW'(fh);
				end
				k_c[2] = NSW'(fh) - NSW'(1);
				k_c[3] = NSW'(fh) - NSW'(1);
				k_c[4] = -NSW'(diff);
				d_c[4] = DW'(fh) << 1;
				ox_c = 1'b1;
			end
		end
	end

	logic v_s2;
	logic signed [AW-1:0] a_s2 [LN];
	logic [SZW-1:0] b_s2 [LN];
	logic signed [NSW-1:0] k_s2 [LN];
	logic [DW-1:0] d_s2 [LN];
	logic [LN-1:0] dbl_s2;
	logic [SBW-1:0] sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= a_c;
			b_s2 <= b_c;
			k_s2 <= k_c;
			d_s2 <= d_c;
			dbl_s2 <= dbl_c;
			sb_s2 <= {!kind_s1, ox_c, oy_c, ax_c, ay_c};
		end
	end

	// stage 3: products
	logic v_s3;
	logic signed [PW-1:0] prod_s3 [LN];
	logic signed [NSW-1:0] k_s3 [LN];
	logic [DW-1:0] d_s3 [LN];
	logic [LN-1:0] dbl_s3;
	logic [SBW-1:0] sb_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LN; l++) begin
				prod_s3[l] <= a_s2[l] * $signed({1'b0, b_s2[l]});
			end
			k_s3 <= k_s2;
			d_s3 <= d_s2;
			dbl_s3 <= dbl_s2;
			sb_s3 <= sb_s2;
		end
	end

	// stage 4: numerators to sign and magnitude
	logic v_s4;
	logic [LN-1:0][NMW-1:0] mag_s4;
	logic [LN-1:0] neg_s4;
	logic [LN-1:0][DW-1:0] d_s4;
	logic [SBW-1:0] sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [NSW-1:0] n;
		if (adv) begin
			for (int l = 0; l < LN; l++) begin
				n = (dbl_s3[l] ? (NSW'(prod_s3[l]) <<< 1) : NSW'(prod_s3[l])) + k_s3[l];
				neg_s4[l] <= n[NSW-1];
				mag_s4[l] <= n[NSW-1] ? NMW'(-n) : NMW'(n);
				d_s4[l] <= d_s3[l];
			end
			sb_s4 <= sb_s3;
		end
	end

	// divide
	logic dv_vld;
	logic [LN-1:0][NMW:0] quo;
	logic [SBW-1:0] dv_sb;

	fmcm_div_pipe #(
		.LANES(LN),
		.NW(NMW),
		.DW(DW),
		.SBW(SBW),
		.SPS(DIV_STEPS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.vld_in(v_s4),
		.num(mag_s4),
		.neg(neg_s4),
		.dsr(d_s4),
		.sb_in(sb_s4),
		.vld_out(dv_vld),
		.quo(quo),
		.sb_out(dv_sb)
	);

	// final: offsets, bounds test, saturation
	logic pt_f, ox_f, oy_f;
	logic signed [CW-1:0] ax_f, ay_f;
	logic signed [FW-1:0] xf, yf, wf, hf;
	logic inside_c;
	logic signed [OUT_XY_W-1:0] ox_sat, oy_sat;
	logic [OUT_WH_W-1:0] w_sat, h_sat;

	assign {pt_f, ox_f, oy_f, ax_f, ay_f} = dv_sb;

	always_comb begin
		xf = FW'($signed(quo[0])) + (ox_f ? FW'($signed(quo[4])) : '0) + FW'(ax_f);
		yf = FW'($signed(quo[1])) + (oy_f ? FW'($signed(quo[4])) : '0) + FW'(ay_f);
		wf = FW'($signed(quo[2]));
		hf = FW'($signed(quo[3]));
		inside_c = pt_f && (!img_q || (xf >= 0 && xf <= $signed(FW'(fw))
			&& yf >= 0 && yf <= $signed(FW'(fh))));
		ox_sat = (xf > X_MAX) ? OUT_XY_W'(X_MAX) : (xf < X_MIN) ? OUT_XY_W'(X_MIN)
			: OUT_XY_W'(xf);
		oy_sat = (yf > X_MAX) ? OUT_XY_W'(X_MAX) : (yf < X_MIN) ? OUT_XY_W'(X_MIN)
			: OUT_XY_W'(yf);
		w_sat = (!pt_f && wf > 0) ? ((wf > W_MAX) ? OUT_WH_W'(W_MAX) : OUT_WH_W'(wf)) : '0;
		h_sat = (!pt_f && hf > 0) ? ((hf > W_MAX) ? OUT_WH_W'(W_MAX) : OUT_WH_W'(hf)) : '0;
	end

	logic rsp_valid_q, pt_q;
	logic signed [OUT_XY_W-1:0] out_x_q, out_y_q;
	logic [OUT_WH_W-1:0] out_w_q, out_h_q;
	logic inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_q <= pt_f;
			out_x_q <= ox_sat;
			out_y_q <= oy_sat;
			out_w_q <= w_sat;
			out_h_q <= h_sat;
			inside_q <= inside_c;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.out_x = out_x_q;
	assign rsp.out_y = out_y_q;
	assign rsp.out_width = out_w_q;
	assign rsp.out_height = out_h_q;
	assign rsp.inside_fb = inside_q;

	a_inside_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.inside_fb |-> rsp.out_width == '0 && rsp.out_height == '0)
		else $error("inside flag on a beat with nonzero size");
	a_rect_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !pt_q |-> !rsp.inside_fb)
		else $error("rect beat carries inside flag");
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> $stable(v_s1) && $stable(v_s4))
		else $error("pipeline moved during stall");
endmodule
`default_nettype wire

[dv/tb_fill_mode_coordinate_mapper.sv]
`timescale 1ns / 100ps
// Testbench for the fill mode coordinate mapper: directed table and mode sweeps, then random beats.
module tb_fill_mode_coordinate_mapper;
	import fmcm_pkg::*;

	localparam int MDB = DEF_MAX_DIM_BITS;
	localparam int FB = DEF_FRAC_BITS;
	localparam int PTW = MDB + FB + 1;
	localparam int SZ = MDB + 1;
	localparam int LAT = 14;
	localparam int N_RAND = 1650;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic kind;
		logic signed [MDB+FB:0] px;
		logic signed [MDB+FB:0] py;
		logic [MDB-1:0] left;
		logic [MDB-1:0] top;
		logic [MDB:0] rw;
		logic [MDB:0] rh;
	} map_req_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
		logic in_fb;
	} map_rsp_t;

	typedef struct {
		map_req_t rq;
		bit has_exp;
		map_rsp_t ex;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic wr_en = 0;
	logic [IDX_W-1:0] wr_idx = '0;
	logic [MDB:0] wr_data = '0;

	fmcm_req_if req();
	fmcm_rsp_if rsp();

	fill_mode_coordinate_mapper dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
		.req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	longint sw, sh, fw, fh;
	fill_mode_t mode;
	bit scale_en, img;

	map_rsp_t expected_q[$];
	int errors = 0;
	longint cycles = 0;
	bit rx_hold = 0;
	bit rx_calm = 0;
	bit tx_calm = 0;

	function automatic longint clamp_s16(longint v);
		return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
	endfunction

	function automatic longint clamp_u15(longint v);
		return v > 32767 ? 32767 : (v < 0 ? 0 : v);
	endfunction

	function automatic longint dim(longint v);
		return v == 0 ? 1 : v;
	endfunction

	function automatic map_rsp_t map_coords(map_req_t r);
		longint W, H, w_fb, h_fb, one, px, py, x, y, w, h, L, T, RW, RH;
		bit wider, fill_w, ins;
		map_rsp_t o;
		W = dim(sw); H = dim(sh); w_fb = dim(fw); h_fb = dim(fh);
		one = longint'(1) << FB;
		wider = w_fb * H > W * h_fb;
		fill_w = (mode == FILL_FIT && wider) || (mode == FILL_CROP && !wider);
		w = 0; h = 0; ins = 0;
		if (!r.kind) begin
			px = longint'(r.px); py = longint'(r.py);
			if (!scale_en || !img) begin
				x = px / one; y = py / one;
			end else if (mode == FILL_STRETCH) begin
				x = (px * w_fb) / (W * one); y = (py * h_fb) / (H * one);
			end else if (mode == FILL_PAD) begin
				x = (px - ((W - w_fb) / 2) * one) / one;
				y = (py - ((H - h_fb) / 2) * one) / one;
			end else if (fill_w) begin
				x = (px * w_fb) / (W * one);
				y = (2 * py * w_fb - (H * w_fb - W * h_fb) * one) / (2 * W * one);
			end else begin
				x = (2 * px * h_fb - (W * h_fb - H * w_fb) * one) / (2 * H * one);
				y = (py * h_fb) / (H * one);
			end
			ins = !img || (x >= 0 && x <= w_fb && y >= 0 && y <= h_fb);
		end else begin
			L = longint'(r.left); T = longint'(r.top);
			RW = longint'(r.rw); RH = longint'(r.rh);
			if (!img) begin
				x = L; y = T; w = RW; h = RH;
			end else if (!scale_en || mode == FILL_PAD) begin
				x = L + (W - w_fb) / 2; y = T + (H - h_fb) / 2; w = RW; h = RH;
			end else if (mode == FILL_STRETCH) begin
				x = (L * W) / w_fb; y = (T * H) / h_fb;
				w = (RW * W) / w_fb; h = (RH * H) / h_fb;
			end else if (fill_w) begin
				x = (L * W) / w_fb;
				y = (T * W) / w_fb + (H * w_fb - W * h_fb) / (2 * w_fb);
				w = (RW * W + w_fb - 1) / w_fb; h = (RH * W + w_fb - 1) / w_fb;
			end else begin
				x = (L * H) / h_fb + (W * h_fb - H * w_fb) / (2 * h_fb);
				y = (T * H) / h_fb;
				w = (RW * H + h_fb - 1) / h_fb; h = (RH * H + h_fb - 1) / h_fb;
			end
		end
		o.x = 16'(clamp_s16(x)); o.y = 16'(clamp_s16(y));
		o.w = 15'(clamp_u15(w)); o.h = 15'(clamp_u15(h));
		o.in_fb = ins;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic write_reg(reg_idx_t idx, longint val);
		wr_en <= 1; wr_idx <= idx; wr_data <= val[MDB:0];
		@(posedge clk);
		wr_en <= 0;
		case (idx)
			REG_SCREEN_W: sw = val & 16'h1fff;
			REG_SCREEN_H: sh = val & 16'h1fff;
			REG_FB_W: fw = val & 16'h1fff;
			REG_FB_H: fh = val & 16'h1fff;
			REG_FILL_MODE: mode = fill_mode_t'(val[1:0]);
			REG_ALLOW_SCALING: scale_en = val[0];
			REG_IMAGE_PRESENT: img = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic set_all(longint a, longint b, longint c, longint d, int m, bit s, bit i);
		write_reg(REG_SCREEN_W, a); write_reg(REG_SCREEN_H, b);
		write_reg(REG_FB_W, c); write_reg(REG_FB_H, d);
		write_reg(REG_FILL_MODE, m); write_reg(REG_ALLOW_SCALING, s);
		write_reg(REG_IMAGE_PRESENT, i);
	endtask

	task automatic send(map_req_t r);
		if (!tx_calm) begin
			while ($urandom_range(99) < 29) begin
				req.valid <= 0;
				@(posedge clk);
			end
		end
		req.valid <= 1;
		{req.kind, req.point_x, req.point_y, req.rect_left, req.rect_top, req.rect_width,
			req.rect_height} <= r;
		expected_q.push_back(map_coords(r));
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic send_checked(map_req_t r, map_rsp_t want);
		map_rsp_t p;
		p = map_coords(r);
		if (p != want) report_mismatch("directed row vs predictor", longint'(p), longint'(want));
		send(r);
	endtask

	function automatic map_req_t rand_req(bit deep);
		map_req_t r;
		r = '0;
		r.kind = 1'($urandom_range(1));
		r.px = PTW'($urandom); r.py = PTW'($urandom);
		r.left = MDB'($urandom); r.top = MDB'($urandom);
		r.rw = SZ'($urandom_range(4096)); r.rh = SZ'($urandom_range(4096));
		if (deep && $urandom_range(3) != 0) begin
			r.px = PTW'($urandom_range(dim(sw) * 16 + 32) - 16);
			r.py = PTW'($urandom_range(dim(sh) * 16 + 32) - 16);
			r.left = MDB'($urandom_range(dim(fw))); r.top = MDB'($urandom_range(dim(fh)));
			r.rw = SZ'($urandom_range(64)); r.rh = SZ'($urandom_range(64));
		end
		if ($urandom_range(15) == 0) r.rw = SZ'($urandom);
		if ($urandom_range(15) == 0) r.rh = SZ'($urandom);
		return r;
	endfunction

	function automatic longint rand_dim();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return 4096;
			3: return $urandom_range(8191);
			default: return $urandom_range(4096, 1);
		endcase
	endfunction

	// receiver
	initial begin
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			rsp.ready <= rx_hold ? 0 : (rx_calm ? 1 : ($urandom_range(99) >= 29));
		end
	end

	// checker
	always @(posedge clk) begin
		map_rsp_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = {rsp.out_x, rsp.out_y, rsp.out_width, rsp.out_height, rsp.inside_fb};
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat", 0, 1);
			end else begin
				want = expected_q.pop_front();
				if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
				if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
				if (got.w !== want.w) report_mismatch("out_width", got.w, want.w);
				if (got.h !== want.h) report_mismatch("out_height", got.h, want.h);
				if (got.in_fb !== want.in_fb)
					report_mismatch("inside_fb", got.in_fb, want.in_fb);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_fill_mode_coordinate_mapper NOT OK");
			$finish;
		end
	end

	function automatic map_req_t mk(bit k, int px, int py, int l, int t, int w, int h);
		map_req_t r;
		r.kind = k; r.px = PTW'(px); r.py = PTW'(py); r.left = MDB'(l); r.top = MDB'(t);
		r.rw = SZ'(w); r.rh = SZ'(h);
		return r;
	endfunction

	function automatic map_rsp_t mo(int x, int y, int w, int h, bit i);
		map_rsp_t o;
		o.x = 16'(x); o.y = 16'(y); o.w = 15'(w); o.h = 15'(h); o.in_fb = i;
		return o;
	endfunction

	initial begin
		dir_row_t rows[$];
		map_req_t r;
		int k;
		req.valid = 0; req.kind = 0; req.point_x = '0; req.point_y = '0;
		req.rect_left = '0; req.rect_top = '0; req.rect_width = '0; req.rect_height = '0;
		sw = RST_SCREEN_W; sh = RST_SCREEN_H; fw = RST_FB_W; fh = RST_FB_H;
		mode = FILL_STRETCH; scale_en = 1; img = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset state, no image: pass-through
		rows.push_back('{mk(0, 160, -33, 0, 0, 0, 0), 1'b1, mo(10, -2, 0, 0, 1)});
		rows.push_back('{mk(0, -65536, 65535, 0, 0, 0, 0), 1'b1, mo(-4096, 4095, 0, 0, 1)});
		rows.push_back('{mk(1, 0, 0, 4095, 4095, 4096, 4096), 1'b1,
			mo(4095, 4095, 4096, 4096, 0)});
		rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0), 1'b1, mo(0, 0, 0, 0, 0)});
		foreach (rows[i]) send_checked(rows[i].rq, rows[i].ex);
		rows.delete();
		tx_calm = 0; req.valid <= 0;
		drain();

		// every mode with an image, extreme sizes included
		for (int m = 0; m < 4; m++) begin
			set_all(m[0] ? 4096 : 0, m[1] ? 1 : 4096, 100, m == 3 ? 0 : 8191, m, 1, 1);
			send(mk(0, 65535, 65535, 0, 0, 0, 0));
			send(mk(0, -65536, -65536, 0, 0, 0, 0));
			send(mk(0, 32, 16, 0, 0, 0, 0));
			send(mk(1, 0, 0, 4095, 4095, 4096, 4096));
			send(mk(1, 0, 0, 7, 3, 1, 0));
			req.valid <= 0;
			drain();
		end
		set_all(640, 480, 1404, 1872, FILL_FIT, 0, 1);
		send(mk(0, 1000, -1000, 0, 0, 0, 0));
		send(mk(1, 0, 0, 10, 10, 20, 20));
		req.valid <= 0;
		drain();

		// random phases over random settings
		k = 0;
		while (k < N_RAND) begin
			case ($urandom_range(3))
				0: set_all(rand_dim(), rand_dim(), rand_dim(), rand_dim(), $urandom_range(3),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				default: set_all($urandom_range(4096, 1), $urandom_range(4096, 1),
					$urandom_range(4096, 1), $urandom_range(4096, 1), $urandom_range(3),
					$urandom_range(9) != 0, $urandom_range(9) != 0);
			endcase
			if (k >= 600 && k < 700) begin
				tx_calm = 1; rx_calm = 1;
			end else begin
				tx_calm = 0; rx_calm = 0;
			end
			if (k == 300) begin
				rx_hold = 1;
				fork
					begin
						repeat (200) @(posedge clk);
						rx_hold = 0;
					end
				join_none
			end
			for (int j = 0; j < 100; j++) begin
				send(rand_req(1));
				k++;
			end
			req.valid <= 0;
			drain();
		end
		tx_calm = 0; rx_calm = 0;
		drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("tb_fill_mode_coordinate_mapper OK");
		end else begin
			$display("tb_fill_mode_coordinate_mapper NOT OK");
		end
		$finish;
	end
endmodule

[fill_mode_coordinate_mapper.f]
src/fmcm_pkg.sv
src/fmcm_if.sv
src/fmcm_div_pipe.sv
src/fill_mode_coordinate_mapper.sv
dv/tb_fill_mode_coordinate_mapper.sv
